FILE: src/fmrl_pkg.sv
// Shared constants, types and helpers for the first-match IPv4 rule lookup unit.
// No dependencies; every other file of the block imports this package.
package fmrl_pkg;

  // table geometry and field widths
  localparam int unsigned MAX_RULES = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_RULES);
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned PROTO_W   = 8;
  localparam int unsigned ENTRY_W   = 6;

  // operation codes
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  // one request travelling down the cell row; the address and protocol
  // slots hold the rule fields for a write and the packet fields for a lookup
  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic [ENTRY_W-1:0]   entry_index;
    logic [ADDR_W-1:0]    addr;
    logic [LEN_W-1:0]     prefix_length;
    logic [PROTO_W-1:0]   proto;
    logic                 any_protocol;
    logic                 hit;
    logic [IDX_W-1:0]     where;
  } item_t;

  // low len bits set, zero length gives an empty mask
  function automatic logic [ADDR_W-1:0] mask_of_length(logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones << len);
  endfunction

endpackage

FILE: src/fmrl_if.sv
// Channel interfaces of the first-match IPv4 rule lookup unit: request,
// response and configuration write. Depends on fmrl_pkg.
interface fmrl_req_if import fmrl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [ENTRY_W-1:0] entry_index;
  logic [ADDR_W-1:0]  rule_address;
  logic [LEN_W-1:0]   prefix_length;
  logic [PROTO_W-1:0] rule_protocol;
  logic               rule_any_protocol;
  logic [ADDR_W-1:0]  query_address;
  logic [PROTO_W-1:0] query_protocol;

  modport source (
    output valid, operation, entry_index, rule_address, prefix_length,
           rule_protocol, rule_any_protocol, query_address, query_protocol,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, rule_address, prefix_length,
           rule_protocol, rule_any_protocol, query_address, query_protocol,
    output ready
  );
endinterface

interface fmrl_rsp_if import fmrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [IDX_W-1:0] match_index;
  logic             was_write;

  modport source (output valid, matched, match_index, was_write, input ready);
  modport sink   (input valid, matched, match_index, was_write, output ready);
endinterface

interface fmrl_cfg_if import fmrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] rules_in_use;

  modport source (output valid, rules_in_use, input ready);
  modport sink   (input valid, rules_in_use, output ready);
endinterface

FILE: src/fmrl_cell.sv
// One rule cell: holds a single table entry, takes writes aimed at it and
// checks passing lookups against it. Depends on fmrl_pkg.
module fmrl_cell import fmrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [CFG_W-1:0] rules_in_use_i,
  input  item_t            item_i,
  output item_t            item_o
);

  logic [ADDR_W-1:0]  addr_q;
  logic [ADDR_W-1:0]  mask_q;
  logic [PROTO_W-1:0] proto_q;
  logic               any_q;
  item_t              item_q;
  item_t              item_d;
  logic               wr_hit;
  logic               in_use;
  logic               rule_match;

  // write decode for this entry
  assign wr_hit = item_i.valid && (item_i.op == OP_WRITE) &&
                  (item_i.entry_index == ENTRY_W'(cell_idx_i)) &&
                  (item_i.prefix_length <= LEN_W'(ADDR_W));

  // entry is searched only below the configured count
  assign in_use = CFG_W'(cell_idx_i) < rules_in_use_i;

  // address under mask and protocol compare
  assign rule_match = (((item_i.addr ^ addr_q) & mask_q) == '0) &&
                      (any_q || (proto_q == item_i.proto));

  // first hit wins, later cells leave it alone
  always_comb begin
    item_d = item_i;
    if (item_i.valid && (item_i.op == OP_LOOKUP) && !item_i.hit &&
        in_use && rule_match) begin
      item_d.hit   = 1'b1;
      item_d.where = cell_idx_i;
    end
  end

  // stored rule
  always_ff @(posedge clk_i) begin
    if (en_i && wr_hit) begin
      addr_q  <= item_i.addr;
      mask_q  <= mask_of_length(item_i.prefix_length);
      proto_q <= item_i.proto;
      any_q   <= item_i.any_protocol;
    end
  end

  // hand the request on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: src/fmrl_out_reg.sv
// Response register at the end of the cell row; sets the advance enable
// of the whole row from downstream ready. Depends on fmrl_pkg.
module fmrl_out_reg import fmrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             ready_i,
  output logic             advance_o,
  output logic             valid_o,
  output logic             matched_o,
  output logic [IDX_W-1:0] match_index_o,
  output logic             was_write_o
);

  logic             valid_q;
  logic             matched_q;
  logic [IDX_W-1:0] index_q;
  logic             write_q;

  // row moves when the response slot is empty or being taken
  assign advance_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= item_i.valid;
    end
  end

  // response fields
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      matched_q <= item_i.hit;
      index_q   <= item_i.hit ? item_i.where : '0;
      write_q   <= (item_i.op == OP_WRITE);
    end
  end

  assign valid_o       = valid_q;
  assign matched_o     = matched_q;
  assign match_index_o = index_q;
  assign was_write_o   = write_q;

endmodule

FILE: src/first_match_ipv4_rule_lookup_unit.sv
// Top level of the first-match IPv4 rule lookup unit: a row of rule cells
// and a response register. Depends on fmrl_pkg, fmrl_if, fmrl_cell, fmrl_out_reg.
//
//   channel  dir  handshake       payload
//   req_i    in   valid / ready   operation, entry_index, rule and query fields
//   rsp_o    out  valid / ready   matched, match_index, was_write
//   cfg_i    in   valid / ready   rules_in_use
//
// One request enters per cycle while the response slot is empty or being taken;
// every request passes one cell per rule entry and then the response register
// before its response is offered.
// A write lands in its cell as it passes, so later lookups see it and earlier
// ones do not. Reset clears the row's valid bits and rules_in_use; stored rules
// are undefined until written. A stalled response freezes the whole row.
module first_match_ipv4_rule_lookup_unit import fmrl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmrl_req_if.sink   req_i,
  fmrl_rsp_if.source rsp_o,
  fmrl_cfg_if.sink   cfg_i
);

  logic             advance;
  logic [CFG_W-1:0] rules_in_use_q;
  item_t            head;
  item_t            chain [MAX_RULES+1];

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_in_use_q <= '0;
    end else if (cfg_i.valid) begin
      rules_in_use_q <= cfg_i.rules_in_use;
    end
  end

  // request enters the row
  assign req_i.ready = advance;

  always_comb begin
    head.valid         = req_i.valid;
    head.op            = op_e'(req_i.operation);
    head.entry_index   = req_i.entry_index;
    head.addr          = req_i.operation ? req_i.rule_address : req_i.query_address;
    head.prefix_length = req_i.prefix_length;
    head.proto         = req_i.operation ? req_i.rule_protocol : req_i.query_protocol;
    head.any_protocol  = req_i.rule_any_protocol;
    head.hit           = 1'b0;
    head.where         = '0;
  end

  assign chain[0] = head;

  // one cell per table entry
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    fmrl_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .en_i           (advance),
      .cell_idx_i     (IDX_W'(g)),
      .rules_in_use_i (rules_in_use_q),
      .item_i         (chain[g]),
      .item_o         (chain[g+1])
    );
  end

  // response register
  fmrl_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (chain[MAX_RULES]),
    .ready_i       (rsp_o.ready),
    .advance_o     (advance),
    .valid_o       (rsp_o.valid),
    .matched_o     (rsp_o.matched),
    .match_index_o (rsp_o.match_index),
    .was_write_o   (rsp_o.was_write)
  );

endmodule

FILE: sim/first_match_ipv4_rule_lookup_unit_tb.sv
// Testbench for the first-match IPv4 rule lookup unit: a bursty request driver,
// a stalling response sink and a table predictor that checks every response.
// Depends on fmrl_pkg, fmrl_if and the first_match_ipv4_rule_lookup_unit RTL.
`timescale 1ns / 1ps

module first_match_ipv4_rule_lookup_unit_tb import fmrl_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LONG_HOLD = 300;

  // one request as the driver offers it
  typedef struct packed {
    op_e                op;
    logic [ENTRY_W-1:0] entry;
    logic [ADDR_W-1:0]  rule_addr;
    logic [LEN_W-1:0]   plen;
    logic [PROTO_W-1:0] rule_proto;
    logic               rule_any;
    logic [ADDR_W-1:0]  query_addr;
    logic [PROTO_W-1:0] query_proto;
  } packet_req_t;

  // one response as the block should return it
  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] index;
    logic             was_write;
  } verdict_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fmrl_req_if req_if ();
  fmrl_rsp_if rsp_if ();
  fmrl_cfg_if cfg_if ();

  first_match_ipv4_rule_lookup_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // rule table as the block should hold it, plus the search depth
  logic [ADDR_W-1:0]  tbl_addr  [MAX_RULES];
  logic [ADDR_W-1:0]  tbl_mask  [MAX_RULES];
  logic [PROTO_W-1:0] tbl_proto [MAX_RULES];
  logic               tbl_any   [MAX_RULES];
  int unsigned        searched_rules;

  // table as the stimulus generator last left it, used to aim lookups at rules
  logic [ADDR_W-1:0]  gen_addr  [MAX_RULES];
  logic [LEN_W-1:0]   gen_len   [MAX_RULES];
  logic [PROTO_W-1:0] gen_proto [MAX_RULES];
  int unsigned        gen_rules;

  packet_req_t request_q[$];
  verdict_t    verdict_q[$];
  packet_req_t in_flight;
  verdict_t    want;
  int unsigned accepted_count;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_cycles;
  int unsigned holds_done;
  int unsigned mode_cycles;
  rx_mode_e    stall_mode;

  // low len bits set, zero length matches every address
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} >> (ADDR_W - len);
  endfunction

  // apply one accepted request to the table and work out its response
  function automatic verdict_t classify_request(input packet_req_t r);
    verdict_t    v;
    int unsigned span;
    v = '0;
    if (r.op == OP_WRITE) begin
      if (r.entry < MAX_RULES && r.plen <= ADDR_W) begin
        tbl_addr[r.entry]  = r.rule_addr;
        tbl_mask[r.entry]  = prefix_mask(r.plen);
        tbl_proto[r.entry] = r.rule_proto;
        tbl_any[r.entry]   = r.rule_any;
      end
      v.was_write = 1'b1;
    end else begin
      span = (searched_rules > MAX_RULES) ? MAX_RULES : searched_rules;
      for (int i = 0; i < span && !v.matched; i++) begin
        if ((r.query_addr & tbl_mask[i]) == (tbl_addr[i] & tbl_mask[i]) &&
            (tbl_any[i] || tbl_proto[i] == r.query_proto)) begin
          v.matched = 1'b1;
          v.index   = i[IDX_W-1:0];
        end
      end
    end
    return v;
  endfunction

  function automatic packet_req_t make_write(input logic [ENTRY_W-1:0] entry,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [LEN_W-1:0] len,
                                             input logic [PROTO_W-1:0] proto,
                                             input logic any);
    packet_req_t r;
    r.op          = OP_WRITE;
    r.entry       = entry;
    r.rule_addr   = addr;
    r.plen        = len;
    r.rule_proto  = proto;
    r.rule_any    = any;
    r.query_addr  = $urandom;
    r.query_proto = PROTO_W'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic packet_req_t make_lookup(input logic [ADDR_W-1:0] addr,
                                              input logic [PROTO_W-1:0] proto);
    packet_req_t r;
    r.op          = OP_LOOKUP;
    r.entry       = ENTRY_W'($urandom_range(0, MAX_RULES - 1));
    r.rule_addr   = $urandom;
    r.plen        = LEN_W'($urandom_range(0, 63));
    r.rule_proto  = PROTO_W'($urandom_range(0, 255));
    r.rule_any    = 1'($urandom_range(0, 1));
    r.query_addr  = addr;
    r.query_proto = proto;
    return r;
  endfunction

  // mostly lookups aimed at rules in use, some blind ones, some rule rewrites
  function automatic packet_req_t random_request();
    packet_req_t        r;
    int unsigned        span;
    int unsigned        j;
    int unsigned        roll;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  m;
    logic [PROTO_W-1:0] proto;
    span = (gen_rules > MAX_RULES) ? MAX_RULES : gen_rules;
    if ($urandom_range(0, 9) < 3) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) len = '0;
      else if (roll == 1) len = LEN_W'(ADDR_W);
      else if (roll < 4) len = LEN_W'($urandom_range(ADDR_W + 1, 63));
      else len = LEN_W'($urandom_range(1, ADDR_W));
      r = make_write(ENTRY_W'($urandom_range(0, MAX_RULES - 1)), $urandom, len,
                     PROTO_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else if (span != 0 && $urandom_range(0, 9) < 7) begin
      j = $urandom_range(0, span - 1);
      m = prefix_mask(gen_len[j]);
      proto = ($urandom_range(0, 3) == 0) ? PROTO_W'($urandom_range(0, 255)) : gen_proto[j];
      r = make_lookup((gen_addr[j] & m) | ($urandom & ~m), proto);
    end else begin
      r = make_lookup($urandom, PROTO_W'($urandom_range(0, 255)));
    end
    return r;
  endfunction

  task automatic push_request(input packet_req_t r);
    if (r.op == OP_WRITE && r.plen <= ADDR_W) begin
      gen_addr[r.entry]  = r.rule_addr;
      gen_len[r.entry]   = r.plen;
      gen_proto[r.entry] = r.rule_proto;
    end
    request_q = {request_q, r};
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) push_request(random_request());
  endtask

  // sampled on the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    while (request_q.size() != 0 || req_if.valid || verdict_q.size() != 0)
      @(negedge clk_i);
  endtask

  // register write only with the block idle
  task automatic set_rules_in_use(input logic [CFG_W-1:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.rules_in_use <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    searched_rules = 32'(v);
    gen_rules      = 32'(v);
    cfg_if.valid  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic note_failure(input string text);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", text);
  endtask

  // request driver: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        verdict_q = {verdict_q, classify_request(in_flight)};
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_flight = request_q.pop_front();
          req_if.operation         <= in_flight.op;
          req_if.entry_index       <= in_flight.entry;
          req_if.rule_address      <= in_flight.rule_addr;
          req_if.prefix_length     <= in_flight.plen;
          req_if.rule_protocol     <= in_flight.rule_proto;
          req_if.rule_any_protocol <= in_flight.rule_any;
          req_if.query_address     <= in_flight.query_addr;
          req_if.query_protocol    <= in_flight.query_proto;
          req_if.valid             <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response sink: stall pattern changes whenever its mode counter runs out,
  // with two long hold-offs that back the row up into the request side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_cycles == 0 && holds_done < 2 && accepted_count >= 150 + 250 * holds_done) begin
        hold_cycles = LONG_HOLD;
        holds_done++;
      end
      if (mode_cycles == 0) begin
        stall_mode  = rx_mode_e'($urandom_range(0, 3));
        mode_cycles = $urandom_range(32, 96);
      end else begin
        mode_cycles--;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_FREE:   rsp_if.ready <= 1'b1;
          RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_if.ready <= ~rsp_if.ready;
        endcase
      end
    end
  end

  // response monitor: each response against the oldest pending verdict
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (verdict_q.size() == 0) begin
        note_failure($sformatf("response with none pending: matched %0b index %0d write %0b",
                               rsp_if.matched, rsp_if.match_index, rsp_if.was_write));
      end else begin
        want = verdict_q.pop_front();
        if (rsp_if.matched !== want.matched)
          note_failure($sformatf("matched: expected %0b, got %0b", want.matched,
                                 rsp_if.matched));
        if (rsp_if.match_index !== want.index)
          note_failure($sformatf("match_index: expected %0d, got %0d", want.index,
                                 rsp_if.match_index));
        if (rsp_if.was_write !== want.was_write)
          note_failure($sformatf("was_write: expected %0b, got %0b", want.was_write,
                                 rsp_if.was_write));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus phases, one search depth each
  initial begin
    rst_ni                   = 1'b0;
    req_if.valid             = 1'b0;
    req_if.operation         = OP_LOOKUP;
    req_if.entry_index       = '0;
    req_if.rule_address      = '0;
    req_if.prefix_length     = '0;
    req_if.rule_protocol     = '0;
    req_if.rule_any_protocol = 1'b0;
    req_if.query_address     = '0;
    req_if.query_protocol    = '0;
    rsp_if.ready             = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.rules_in_use      = '0;
    searched_rules           = 0;
    gen_rules                = 0;
    accepted_count           = 0;
    fail_count               = 0;
    cycle_count              = 0;
    burst_left               = 0;
    gap_left                 = 0;
    hold_cycles              = 0;
    holds_done               = 0;
    mode_cycles              = 0;
    stall_mode               = RX_FREE;

    // empty search after reset, extreme rules, ignored long prefixes
    push_request(make_lookup('0, '0));
    push_request(make_lookup('1, '1));
    push_request(make_write('0, '1, LEN_W'(ADDR_W), '1, 1'b0));
    push_request(make_write(ENTRY_W'(MAX_RULES - 1), '0, '0, '0, 1'b1));
    push_request(make_write(ENTRY_W'(1), '1, LEN_W'(ADDR_W + 1), '1, 1'b1));
    push_request(make_write(ENTRY_W'(2), '1, LEN_W'(63), '1, 1'b0));
    push_request(make_lookup('1, '1));
    // fill the rest of the table so no lookup ever reads an unwritten entry
    for (int e = 1; e < MAX_RULES - 1; e++)
      push_request(make_write(ENTRY_W'(e), $urandom, LEN_W'($urandom_range(1, ADDR_W)),
                              PROTO_W'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full table: exact hit on entry 0, an ignored rewrite of it, catch-all at 63
    set_rules_in_use(CFG_W'(MAX_RULES));
    push_request(make_lookup('1, '1));
    push_request(make_write('0, '0, LEN_W'(40), '0, 1'b1));
    push_request(make_lookup('1, '1));
    push_request(make_lookup('1, 8'hFE));
    push_request(make_lookup('0, '0));
    push_random(150);

    set_rules_in_use(CFG_W'(1));
    push_random(60);
    // depth beyond the table size
    set_rules_in_use('1);
    push_random(120);
    set_rules_in_use(CFG_W'($urandom_range(2, MAX_RULES - 1)));
    push_random(120);
    set_rules_in_use(CFG_W'($urandom_range(MAX_RULES + 1, 126)));
    push_random(80);
    set_rules_in_use('0);
    push_random(40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fmrl_pkg.sv
src/fmrl_if.sv
src/fmrl_cell.sv
src/fmrl_out_reg.sv
src/first_match_ipv4_rule_lookup_unit.sv
sim/first_match_ipv4_rule_lookup_unit_tb.sv
